@@ design/ftc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftc_pkg
// shared types and constants of the force trigger capture block
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

  localparam int unsigned THR_W  = 15;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FRC_W  = 16;
  localparam int unsigned DSP_W  = 24;

  // configuration register indexes
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  // input action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CANCEL = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [THR_W-1:0]        LOW_RESET   = 15'd100;
  localparam logic [THR_W-1:0]        HIGH_RESET  = 15'd1000;
  localparam logic signed [FRC_W-1:0] FRC_RESET   = 16'sd100;
  localparam logic signed [DSP_W-1:0] DISP_FAR    = 24'sd100000;
  localparam logic signed [DSP_W-1:0] DISP_FAR_NG = -24'sd100000;

  typedef struct packed {
    logic [TIME_W-1:0]        tstamp;
    logic signed [FRC_W-1:0]  frc;
    logic signed [DSP_W-1:0]  dsp;
  } sample_t;

  typedef struct packed {
    logic                     kind;
    logic                     armed;
    logic [TIME_W-1:0]        tstamp;
    logic signed [FRC_W-1:0]  frc;
    logic signed [DSP_W-1:0]  dsp;
    logic                     last;
    logic signed [FRC_W-1:0]  live_pf;
    logic signed [DSP_W-1:0]  live_ld;
    logic signed [DSP_W-1:0]  live_hd;
    logic signed [FRC_W-1:0]  sav_pf;
    logic signed [DSP_W-1:0]  sav_ld;
    logic signed [DSP_W-1:0]  sav_hd;
  } result_t;

endpackage

`default_nettype wire

@@ design/force_trigger_capture.sv @@
// ----------------------------------------------------------------------------
// force_trigger_capture
// hysteresis triggered capture of time, force and displacement samples
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one item is a new sample or a cancel.
//   each sample is written into a ring of the newest DEPTH samples in a ram.
//   result channel (out_valid / out_stall): every item gives one status item,
//   except a sample that completes a run of at least MIN_RUN samples, which
//   gives the run samples oldest first, the final one flagged out_last_of_run.
//   cfg_wr_en / cfg_index / cfg_wdata write the low and high thresholds; write
//   them only while the block is idle.
// timing
//   after an accept, in_stall stays high until the item's status item or last
//   run sample is loaded into the free output register. a trigger end walks
//   back through the ring one stored sample per cycle (one ram read port),
//   then dumps the run one sample per cycle unless out_stall holds it.
// reset
//   synchronous rst_n clears the ring count, write slot, armed flag, both
//   thresholds and all extrema to their start values; the ram needs no pass.
// stall
//   the output register holds its item while out_stall is high; an item is
//   still accepted while a result waits, then the block waits for the register
// ----------------------------------------------------------------------------
`default_nettype none

module force_trigger_capture import ftc_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int MIN_RUN = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic                    in_action,
  input  wire logic [TIME_W-1:0]       in_sample_time,
  input  wire logic signed [FRC_W-1:0] in_sample_force,
  input  wire logic signed [DSP_W-1:0] in_sample_displacement,
  // configuration write port
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_index,
  input  wire logic [THR_W-1:0]        cfg_wdata,
  // result channel
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    out_result_kind,
  output      logic                    out_armed,
  output      logic [TIME_W-1:0]       out_time,
  output      logic signed [FRC_W-1:0] out_force,
  output      logic signed [DSP_W-1:0] out_displacement,
  output      logic                    out_last_of_run,
  output      logic signed [FRC_W-1:0] out_live_peak_force,
  output      logic signed [DSP_W-1:0] out_live_low_disp,
  output      logic signed [DSP_W-1:0] out_live_high_disp,
  output      logic signed [FRC_W-1:0] out_saved_peak_force,
  output      logic signed [DSP_W-1:0] out_saved_low_disp,
  output      logic signed [DSP_W-1:0] out_saved_high_disp
);

  localparam int SLOT_W = $clog2(DEPTH);

  // ram port between sequencer and sample ring
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  sample_t           ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [$bits(sample_t)-1:0] ram_rdata;

  // sequencer to output register
  logic    res_load;
  logic    out_free;
  result_t res;
  result_t out_res;

  // one ram word holds a whole sample
  ftc_ram #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // trigger decision, run scan and run dump
  ftc_seq #(
    .DEPTH   (DEPTH),
    .MIN_RUN (MIN_RUN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_tstamp (in_sample_time),
    .in_frc    (in_sample_force),
    .in_dsp    (in_sample_displacement),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (sample_t'(ram_rdata))
  );

  // result register decouples the sequencer from the receiver
  ftc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // unpack the result item onto its ports
  assign out_result_kind      = out_res.kind;
  assign out_armed            = out_res.armed;
  assign out_time             = out_res.tstamp;
  assign out_force            = out_res.frc;
  assign out_displacement     = out_res.dsp;
  assign out_last_of_run      = out_res.last;
  assign out_live_peak_force  = out_res.live_pf;
  assign out_live_low_disp    = out_res.live_ld;
  assign out_live_high_disp   = out_res.live_hd;
  assign out_saved_peak_force = out_res.sav_pf;
  assign out_saved_low_disp   = out_res.sav_ld;
  assign out_saved_high_disp  = out_res.sav_hd;

endmodule

`default_nettype wire

@@ design/ftc_ram.sv @@
// ----------------------------------------------------------------------------
// ftc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/ftc_seq.sv @@
// ----------------------------------------------------------------------------
// ftc_seq
// sequencer: ring pointers, trigger logic, backward run scan, run emission
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_seq import ftc_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int MIN_RUN = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic                      in_action,
  input  wire logic [TIME_W-1:0]         in_tstamp,
  input  wire logic signed [FRC_W-1:0]   in_frc,
  input  wire logic signed [DSP_W-1:0]   in_dsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_index,
  input  wire logic [THR_W-1:0]          cfg_wdata,
  input  wire logic                      out_free,
  output      logic                      res_load,
  output      result_t                   res,
  output      logic                      ram_we,
  output      logic [$clog2(DEPTH)-1:0]  ram_waddr,
  output      sample_t                   ram_wdata,
  output      logic                      ram_re,
  output      logic [$clog2(DEPTH)-1:0]  ram_raddr,
  input  wire sample_t                   ram_rdata
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STAT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(DEPTH - 1) : s - 1'b1;
  endfunction

  function automatic logic signed [FRC_W-1:0] max_f(input logic signed [FRC_W-1:0] a,
                                                   input logic signed [FRC_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic signed [DSP_W-1:0] max_d(input logic signed [DSP_W-1:0] a,
                                                   input logic signed [DSP_W-1:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic logic signed [DSP_W-1:0] min_d(input logic signed [DSP_W-1:0] a,
                                                   input logic signed [DSP_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [THR_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SLOT_W-1:0]       wslot_r, wslot_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    armed_r, armed_nxt;
  logic signed [FRC_W-1:0] prev_f_r, prev_f_nxt;
  logic signed [FRC_W-1:0] live_pf_r, live_pf_nxt;
  logic signed [DSP_W-1:0] live_ld_r, live_ld_nxt, live_hd_r, live_hd_nxt;
  logic signed [FRC_W-1:0] sav_pf_r, sav_pf_nxt;
  logic signed [DSP_W-1:0] sav_ld_r, sav_ld_nxt, sav_hd_r, sav_hd_nxt;
  logic signed [FRC_W-1:0] cur_f_r, cur_f_nxt;
  logic signed [DSP_W-1:0] cur_d_r, cur_d_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [SLOT_W-1:0]       scan_slot_r, scan_slot_nxt;
  logic signed [FRC_W-1:0] acc_pf_r, acc_pf_nxt;
  logic signed [DSP_W-1:0] acc_ld_r, acc_ld_nxt, acc_hd_r, acc_hd_nxt;
  logic [CNT_W-1:0]        left_r, left_nxt;
  logic [SLOT_W-1:0]       rd_slot_r, rd_slot_nxt;

  logic signed [FRC_W-1:0] lo_s, hi_s;
  logic                    accept, arm_set, armed_mid, fin, stop;
  logic signed [FRC_W-1:0] scan_pf;
  logic signed [DSP_W-1:0] scan_ld, scan_hd;
  logic [CNT_W-1:0]        run_len;
  logic                    run_ok;

  always_comb begin
    lo_s      = signed'({1'b0, lo_r});
    hi_s      = signed'({1'b0, hi_r});
    accept    = (state_r == ST_IDLE) && in_valid;
    // trigger needs a previous stored sample
    arm_set   = (count_r != '0) && !armed_r && (prev_f_r < hi_s) && (hi_s <= in_frc);
    armed_mid = armed_r || arm_set;
    fin       = (count_r != '0) && armed_mid && (in_frc <= lo_s) && (lo_s < prev_f_r);
    scan_pf   = max_f(acc_pf_r, ram_rdata.frc);
    scan_ld   = min_d(acc_ld_r, ram_rdata.dsp);
    scan_hd   = max_d(acc_hd_r, ram_rdata.dsp);
    stop      = (ram_rdata.frc < lo_s) || (idx_r == '0);
    run_len   = count_r - idx_r;
    run_ok    = 32'(run_len) >= 32'(MIN_RUN);
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    wslot_nxt     = wslot_r;
    count_nxt     = count_r;
    armed_nxt     = armed_r;
    prev_f_nxt    = prev_f_r;
    live_pf_nxt   = live_pf_r;
    live_ld_nxt   = live_ld_r;
    live_hd_nxt   = live_hd_r;
    sav_pf_nxt    = sav_pf_r;
    sav_ld_nxt    = sav_ld_r;
    sav_hd_nxt    = sav_hd_r;
    cur_f_nxt     = cur_f_r;
    cur_d_nxt     = cur_d_r;
    idx_nxt       = idx_r;
    scan_slot_nxt = scan_slot_r;
    acc_pf_nxt    = acc_pf_r;
    acc_ld_nxt    = acc_ld_r;
    acc_hd_nxt    = acc_hd_r;
    left_nxt      = left_r;
    rd_slot_nxt   = rd_slot_r;

    in_stall      = (state_r != ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = wslot_r;
    ram_wdata     = '{tstamp: in_tstamp, frc: in_frc, dsp: in_dsp};
    ram_re        = 1'b0;
    ram_raddr     = slot_dec(wslot_r);
    res_load      = 1'b0;

    res.kind    = KIND_STATUS;
    res.armed   = armed_r;
    res.tstamp  = '0;
    res.frc     = '0;
    res.dsp     = '0;
    res.last    = 1'b1;
    res.live_pf = live_pf_r;
    res.live_ld = live_ld_r;
    res.live_hd = live_hd_r;
    res.sav_pf  = sav_pf_r;
    res.sav_ld  = sav_ld_r;
    res.sav_hd  = sav_hd_r;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LOW:  lo_nxt = cfg_wdata;
        REG_HIGH: hi_nxt = cfg_wdata;
        default:  ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_CANCEL) begin
            armed_nxt = 1'b0;
            state_nxt = ST_STAT;
          end else begin
            ram_we     = 1'b1;
            wslot_nxt  = slot_inc(wslot_r);
            count_nxt  = (count_r == CNT_W'(DEPTH)) ? count_r : count_r + 1'b1;
            prev_f_nxt = in_frc;
            cur_f_nxt  = in_frc;
            cur_d_nxt  = in_dsp;
            if (fin) begin
              // previous sample read now, walk back from it
              armed_nxt     = 1'b0;
              ram_re        = 1'b1;
              idx_nxt       = count_nxt - CNT_W'(2);
              scan_slot_nxt = slot_dec(wslot_r);
              acc_pf_nxt    = max_f(lo_s, in_frc);
              acc_ld_nxt    = min_d(DISP_FAR, in_dsp);
              acc_hd_nxt    = max_d(DISP_FAR_NG, in_dsp);
              state_nxt     = ST_SCAN;
            end else begin
              armed_nxt   = armed_mid;
              live_pf_nxt = max_f(live_pf_r, in_frc);
              live_ld_nxt = min_d(live_ld_r, in_dsp);
              live_hd_nxt = max_d(live_hd_r, in_dsp);
              state_nxt   = ST_STAT;
            end
          end
        end
      end
      ST_STAT: begin
        res_load = out_free;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stop) begin
          acc_pf_nxt    = scan_pf;
          acc_ld_nxt    = scan_ld;
          acc_hd_nxt    = scan_hd;
          idx_nxt       = idx_r - 1'b1;
          scan_slot_nxt = slot_dec(scan_slot_r);
          ram_re        = 1'b1;
          ram_raddr     = slot_dec(scan_slot_r);
        end else if (run_ok) begin
          sav_pf_nxt  = scan_pf;
          sav_ld_nxt  = scan_ld;
          sav_hd_nxt  = scan_hd;
          count_nxt   = CNT_W'(1);
          live_pf_nxt = max_f(lo_s, cur_f_r);
          live_ld_nxt = min_d(DISP_FAR, cur_d_r);
          live_hd_nxt = max_d(DISP_FAR_NG, cur_d_r);
          ram_re      = 1'b1;
          ram_raddr   = scan_slot_r;
          rd_slot_nxt = scan_slot_r;
          left_nxt    = run_len;
          state_nxt   = ST_EMIT;
        end else begin
          live_pf_nxt = max_f(live_pf_r, cur_f_r);
          live_ld_nxt = min_d(live_ld_r, cur_d_r);
          live_hd_nxt = max_d(live_hd_r, cur_d_r);
          state_nxt   = ST_STAT;
        end
      end
      ST_EMIT: begin
        res.kind   = KIND_SAMPLE;
        res.tstamp = ram_rdata.tstamp;
        res.frc    = ram_rdata.frc;
        res.dsp    = ram_rdata.dsp;
        res.last   = (left_r == CNT_W'(1));
        res_load   = out_free;
        if (out_free) begin
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            left_nxt    = left_r - 1'b1;
            rd_slot_nxt = slot_inc(rd_slot_r);
            ram_re      = 1'b1;
            ram_raddr   = slot_inc(rd_slot_r);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lo_r      <= LOW_RESET;
      hi_r      <= HIGH_RESET;
      wslot_r   <= '0;
      count_r   <= '0;
      armed_r   <= 1'b0;
      live_pf_r <= FRC_RESET;
      live_ld_r <= DISP_FAR;
      live_hd_r <= DISP_FAR_NG;
      sav_pf_r  <= FRC_RESET;
      sav_ld_r  <= '0;
      sav_hd_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      wslot_r   <= wslot_nxt;
      count_r   <= count_nxt;
      armed_r   <= armed_nxt;
      live_pf_r <= live_pf_nxt;
      live_ld_r <= live_ld_nxt;
      live_hd_r <= live_hd_nxt;
      sav_pf_r  <= sav_pf_nxt;
      sav_ld_r  <= sav_ld_nxt;
      sav_hd_r  <= sav_hd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_f_r    <= prev_f_nxt;
    cur_f_r     <= cur_f_nxt;
    cur_d_r     <= cur_d_nxt;
    idx_r       <= idx_nxt;
    scan_slot_r <= scan_slot_nxt;
    acc_pf_r    <= acc_pf_nxt;
    acc_ld_r    <= acc_ld_nxt;
    acc_hd_r    <= acc_hd_nxt;
    left_r      <= left_nxt;
    rd_slot_r   <= rd_slot_nxt;
  end

endmodule

`default_nettype wire

@@ design/ftc_out.sv @@
// ----------------------------------------------------------------------------
// ftc_out
// result output register with valid and stall handshake
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_out import ftc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_load,
  input  wire result_t res,
  output      logic    out_free,
  output      logic    out_valid,
  input  wire logic    out_stall,
  output      result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    out_free  = !valid_r || !out_stall;
    valid_nxt = res_load || (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

@@ bench/ftc_checker.sv @@
// ----------------------------------------------------------------------------
// ftc_checker
// watches the sample and result channels of force_trigger_capture, predicts
// every result from its own copy of the ring, trigger and extrema, and counts
// results that differ or arrive with nothing awaited
// ----------------------------------------------------------------------------
module ftc_checker import ftc_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int MIN_RUN = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_action,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic signed [FRC_W-1:0] in_sample_force,
  input  logic signed [DSP_W-1:0] in_sample_displacement,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_index,
  input  logic [THR_W-1:0]        cfg_wdata,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_result_kind,
  input  logic                    out_armed,
  input  logic [TIME_W-1:0]       out_time,
  input  logic signed [FRC_W-1:0] out_force,
  input  logic signed [DSP_W-1:0] out_displacement,
  input  logic                    out_last_of_run,
  input  logic signed [FRC_W-1:0] out_live_peak_force,
  input  logic signed [DSP_W-1:0] out_live_low_disp,
  input  logic signed [DSP_W-1:0] out_live_high_disp,
  input  logic signed [FRC_W-1:0] out_saved_peak_force,
  input  logic signed [DSP_W-1:0] out_saved_low_disp,
  input  logic signed [DSP_W-1:0] out_saved_high_disp,
  output int                      mismatches,
  output int                      pending,
  output int                      runs_captured,
  output int                      results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic [TIME_W-1:0] ring_time [DEPTH];
  int                ring_force [DEPTH];
  int                ring_disp [DEPTH];
  int                stored;
  int                wr_slot;
  bit                armed_now;
  int                live_pf, live_ld, live_hd;
  int                sav_pf, sav_ld, sav_hd;
  int                low_thr, high_thr;
  result_t           awaited_results [$];

  function automatic void clear_model();
    stored          = 0;
    wr_slot         = 0;
    armed_now       = 1'b0;
    low_thr         = int'(LOW_RESET);
    high_thr        = int'(HIGH_RESET);
    live_pf         = int'(FRC_RESET);
    live_ld         = int'(DISP_FAR);
    live_hd         = int'(DISP_FAR_NG);
    sav_pf          = int'(FRC_RESET);
    sav_ld          = 0;
    sav_hd          = 0;
    mismatches      = 0;
    runs_captured   = 0;
    results_checked = 0;
    awaited_results.delete();
  endfunction

  function automatic result_t shape_result(logic kind, logic [TIME_W-1:0] t, int f, int d,
                                           logic last);
    result_t r;
    r.kind    = kind;
    r.armed   = armed_now;
    r.tstamp  = t;
    r.frc     = f[FRC_W-1:0];
    r.dsp     = d[DSP_W-1:0];
    r.last    = last;
    r.live_pf = live_pf[FRC_W-1:0];
    r.live_ld = live_ld[DSP_W-1:0];
    r.live_hd = live_hd[DSP_W-1:0];
    r.sav_pf  = sav_pf[FRC_W-1:0];
    r.sav_ld  = sav_ld[DSP_W-1:0];
    r.sav_hd  = sav_hd[DSP_W-1:0];
    return r;
  endfunction

  // append one predicted result at the tail of the queue
  function automatic void await_result(result_t r);
    awaited_results = {awaited_results, r};
  endfunction

  // one accepted item: update ring, trigger and extrema, queue its results
  function automatic void predict_capture_step(logic act, logic [TIME_W-1:0] t, int f, int d);
    int lo, hi, n, oldest, prev, start, base, len, k, s;
    bit captured;
    captured = 1'b0;
    base     = 0;
    len      = 0;
    if (act == ACT_CANCEL) begin
      armed_now = 1'b0;
      await_result(shape_result(KIND_STATUS, '0, 0, 0, 1'b1));
      return;
    end
    lo = low_thr;
    hi = high_thr;
    ring_time[wr_slot]  = t;
    ring_force[wr_slot] = f;
    ring_disp[wr_slot]  = d;
    wr_slot = (wr_slot + 1) % DEPTH;
    if (stored < DEPTH) stored++;
    n = stored;
    if (n >= 2) begin
      oldest = (wr_slot + DEPTH - n) % DEPTH;
      prev   = ring_force[(oldest + n - 2) % DEPTH];
      if (!armed_now && prev < hi && hi <= f) armed_now = 1'b1;
      if (armed_now && f <= lo && lo < prev) begin
        // walk back to the newest earlier sample under the low level
        start = n - 2;
        while (start > 0 && ring_force[(oldest + start) % DEPTH] >= lo) start--;
        if (n - start >= MIN_RUN) begin
          captured = 1'b1;
          base     = (oldest + start) % DEPTH;
          len      = n - start;
          sav_pf   = lo;
          sav_ld   = int'(DISP_FAR);
          sav_hd   = int'(DISP_FAR_NG);
          for (k = 0; k < len; k++) begin
            s = (base + k) % DEPTH;
            if (ring_force[s] > sav_pf) sav_pf = ring_force[s];
            if (ring_disp[s] < sav_ld) sav_ld = ring_disp[s];
            if (ring_disp[s] > sav_hd) sav_hd = ring_disp[s];
          end
          stored  = 1;
          live_pf = lo;
          live_ld = int'(DISP_FAR);
          live_hd = int'(DISP_FAR_NG);
          runs_captured++;
        end
        armed_now = 1'b0;
      end
    end
    if (f > live_pf) live_pf = f;
    if (d < live_ld) live_ld = d;
    if (d > live_hd) live_hd = d;
    if (!captured) begin
      await_result(shape_result(KIND_STATUS, '0, 0, 0, 1'b1));
    end else begin
      for (k = 0; k < len; k++) begin
        s = (base + k) % DEPTH;
        await_result(shape_result(KIND_SAMPLE, ring_time[s], ring_force[s],
                                  ring_disp[s], k == len - 1));
      end
    end
  endfunction

  function automatic string show(result_t r);
    return $sformatf({"kind %0d armed %0d time %h force %0d disp %0d last %0d",
                      " live %0d/%0d/%0d saved %0d/%0d/%0d"},
                     r.kind, r.armed, r.tstamp, r.frc, r.dsp, r.last,
                     r.live_pf, r.live_ld, r.live_hd, r.sav_pf, r.sav_ld, r.sav_hd);
  endfunction

  function automatic void check_result();
    result_t got, want;
    got.kind    = out_result_kind;
    got.armed   = out_armed;
    got.tstamp  = out_time;
    got.frc     = out_force;
    got.dsp     = out_displacement;
    got.last    = out_last_of_run;
    got.live_pf = out_live_peak_force;
    got.live_ld = out_live_low_disp;
    got.live_hd = out_live_high_disp;
    got.sav_pf  = out_saved_peak_force;
    got.sav_ld  = out_saved_low_disp;
    got.sav_hd  = out_saved_high_disp;
    results_checked++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%t: result with nothing awaited: %s", $realtime, show(got));
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%t: result %0d differs", $realtime, results_checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_LOW) low_thr = int'(cfg_wdata);
        else high_thr = int'(cfg_wdata);
      end
      if (in_valid && !in_stall)
        predict_capture_step(in_action, in_sample_time, in_sample_force,
                             in_sample_displacement);
      if (out_valid && !out_stall) check_result();
    end
    pending = awaited_results.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for force_trigger_capture: directed trigger cases, then
// random force pulses and noise under five threshold settings, with random
// idling on both channels and a long result hold-off; ftc_checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module tb;
  import ftc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 32;
  localparam int MIN_RUN        = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 8;     // settle time before a threshold write
  localparam int TAIL_CYCLES    = 40;    // quiet wait once nothing is awaited
  localparam int HOLD_CYCLES    = 80;    // long result hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no accept on any channel
  localparam int FRC_MIN        = -32768;
  localparam int FRC_MAX        = 32767;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_action = ACT_SAMPLE;
  logic [TIME_W-1:0]       in_sample_time = '0;
  logic signed [FRC_W-1:0] in_sample_force = '0;
  logic signed [DSP_W-1:0] in_sample_displacement = '0;
  logic                    cfg_wr_en = 1'b0;
  logic                    cfg_index = REG_LOW;
  logic [THR_W-1:0]        cfg_wdata = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_result_kind;
  logic                    out_armed;
  logic [TIME_W-1:0]       out_time;
  logic signed [FRC_W-1:0] out_force;
  logic signed [DSP_W-1:0] out_displacement;
  logic                    out_last_of_run;
  logic signed [FRC_W-1:0] out_live_peak_force;
  logic signed [DSP_W-1:0] out_live_low_disp;
  logic signed [DSP_W-1:0] out_live_high_disp;
  logic signed [FRC_W-1:0] out_saved_peak_force;
  logic signed [DSP_W-1:0] out_saved_low_disp;
  logic signed [DSP_W-1:0] out_saved_high_disp;

  int mismatches, pending, runs_captured, results_checked;

  // stimulus side bookkeeping
  int                cur_lo = int'(LOW_RESET);
  int                cur_hi = int'(HIGH_RESET);
  int                items_sent = 0;
  int                cancels_sent = 0;
  logic [TIME_W-1:0] sample_clock = '0;
  int                send_idle_pct = 10;
  int                recv_idle_pct = 79;
  bit                pressure_on = 1'b0;

  // receiver side: hold counters written only by the receiver process, and the watchdog count
  int hold_left = 0;
  bit hold_served = 1'b0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  force_trigger_capture #(.DEPTH(DEPTH), .MIN_RUN(MIN_RUN)) dut (.*);

  ftc_checker #(.DEPTH(DEPTH), .MIN_RUN(MIN_RUN)) checker_i (.*);

  // receiver: random stalls, plus one long hold-off each time pressure is
  // switched on, so the output register backs up into the input channel
  always @(negedge clk) begin
    if (!pressure_on) begin
      hold_served = 1'b0;
    end else if (!hold_served) begin
      hold_left   = HOLD_CYCLES;
      hold_served = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: any accept on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results still awaited",
               WATCHDOG_LIMIT, pending);
      $display("force_trigger_capture verification failed");
      $finish;
    end
  end

  // uniform pick in [lo_b, hi_b]; an empty range falls back to any force
  function automatic int pick(int lo_b, int hi_b);
    int v;
    if (lo_b > hi_b) v = $urandom_range(65535) - 32768;
    else v = lo_b + int'($urandom_range(hi_b - lo_b));
    return v;
  endfunction

  function automatic logic [TIME_W-1:0] next_time();
    // mostly a rising clock in tenths, now and then a jump anywhere
    if ($urandom_range(31) == 0) sample_clock = $urandom();
    else sample_clock = sample_clock + $urandom_range(1, 20);
    return sample_clock;
  endfunction

  function automatic int rand_disp();
    int v;
    // half full range, half near the live extrema start values
    if ($urandom_range(1)) v = pick(-8388608, 8388607);
    else v = pick(-150000, 150000);
    return v;
  endfunction

  // present one item from a falling edge after random idling, hold it until accepted
  task automatic send_item(logic act, logic [TIME_W-1:0] t, int f, int d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid               <= 1'b1;
    in_action              <= act;
    in_sample_time         <= t;
    in_sample_force        <= f[FRC_W-1:0];
    in_sample_displacement <= d[DSP_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_CANCEL) cancels_sent++;
  endtask

  task automatic send_sample(int f);
    send_item(ACT_SAMPLE, next_time(), f, rand_disp());
  endtask

  task automatic send_cancel();
    // cancel carries random payload bits, which the block ignores
    send_item(ACT_CANCEL, $urandom(), pick(FRC_MIN, FRC_MAX), rand_disp());
  endtask

  // wait for all results, let the block settle, then write one threshold
  task automatic write_threshold(logic idx, int val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[THR_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_LOW) cur_lo = val;
    else cur_hi = val;
  endtask

  // well formed pulse: quiet below both levels, rise past high, optional
  // fall above low, then a drop to or under low that ends the trigger
  task automatic send_pulse(bit go_long);
    int n_pre, n_peak, n_fall, k;
    n_pre  = $urandom_range(1, 3);
    n_peak = go_long ? $urandom_range(28, 40) : $urandom_range(1, 8);
    n_fall = $urandom_range(0, 2);
    for (k = 0; k < n_pre; k++)
      send_sample(pick(FRC_MIN, (cur_lo < cur_hi ? cur_lo : cur_hi) - 1));
    for (k = 0; k < n_peak; k++)
      send_sample(pick(cur_hi > cur_lo + 1 ? cur_hi : cur_lo + 1, FRC_MAX));
    // occasionally break the sequence with a cancel
    if ($urandom_range(11) == 0) send_cancel();
    for (k = 0; k < n_fall; k++)
      send_sample(pick(cur_lo + 1, FRC_MAX));
    send_sample(pick(FRC_MIN, cur_lo));
  endtask

  task automatic send_noise();
    int n, k;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(5) == 0) send_cancel();
      else send_sample(pick(FRC_MIN, FRC_MAX));
    end
  endtask

  task automatic run_random(int n_items, bit long_first);
    int first_item;
    first_item = items_sent;
    if (long_first) send_pulse(1'b1);
    while (items_sent - first_item < n_items) begin
      if ($urandom_range(3) == 0) send_noise();
      else send_pulse($urandom_range(19) == 0);
    end
  endtask

  initial begin
    int v;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset thresholds (low 100, high 1000)
    // field extremes on the first two samples; the second one arms
    send_item(ACT_SAMPLE, '0, FRC_MIN, -8388608);
    send_item(ACT_SAMPLE, '1, FRC_MAX, 8388607);
    send_cancel();                       // cancel while armed
    send_cancel();                       // cancel while idle
    send_item(ACT_SAMPLE, next_time(), 2000, 0);        // previous above high, no arm
    send_item(ACT_SAMPLE, next_time(), 50, -100001);    // end shape but not armed
    send_item(ACT_SAMPLE, next_time(), 1000, 100001);   // force exactly at high arms
    send_item(ACT_SAMPLE, next_time(), 100, 7);         // exactly at low, run too short
    // run of exactly the minimum length
    send_item(ACT_SAMPLE, next_time(), 99, -3);
    send_item(ACT_SAMPLE, next_time(), 1500, 250000);
    send_item(ACT_SAMPLE, next_time(), 30000, -250000);
    send_item(ACT_SAMPLE, next_time(), 400, 12);
    send_item(ACT_SAMPLE, next_time(), 100, 13);
    // nothing under low is kept, so the run starts at the oldest sample
    send_item(ACT_SAMPLE, next_time(), 5000, 1);
    send_item(ACT_SAMPLE, next_time(), 6000, -1);
    send_item(ACT_SAMPLE, next_time(), 7000, 99999);
    send_item(ACT_SAMPLE, next_time(), 200, -99999);
    send_item(ACT_SAMPLE, next_time(), 0, 0);
    send_cancel();
    send_item(ACT_SAMPLE, next_time(), -1, 8388607);

    // reset thresholds, a long pulse first to wrap the ring
    run_random(20, 1'b1);

    // extremes: low at zero, high at full scale
    write_threshold(REG_LOW, 0);
    write_threshold(REG_HIGH, 32767);
    run_random(15, 1'b0);

    // roles swapped: sender idles often, receiver rarely
    send_idle_pct = 79;
    recv_idle_pct = 10;

    // low above high; a trigger can arm but never end
    write_threshold(REG_LOW, 32767);
    write_threshold(REG_HIGH, 0);
    pressure_on = 1'b1;
    send_pulse(1'b0);
    pressure_on = 1'b0;
    run_random(15, 1'b0);

    v = $urandom_range(3000);
    write_threshold(REG_LOW, v);
    write_threshold(REG_HIGH, v + $urandom_range(5000));
    run_random(25, 1'b0);

    // no idling; both levels equal, long run dumped against a held receiver
    send_idle_pct = 0;
    recv_idle_pct = 0;
    v = $urandom_range(500, 20000);
    write_threshold(REG_LOW, v);
    write_threshold(REG_HIGH, v);
    pressure_on = 1'b1;
    send_pulse(1'b1);
    pressure_on = 1'b0;
    run_random(15, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d items (%0d cancels) over five threshold settings and three idle mixes",
             items_sent, cancels_sent);
    $display("checked %0d results, %0d captured runs, %0d mismatches",
             results_checked, runs_captured, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("force_trigger_capture verification clean");
    end else begin
      $display("force_trigger_capture verification failed");
    end
    $finish;
  end

endmodule
